@@ sv/czs_pkg.sv @@
// ----------------------------------------------------------------------------
// czs_pkg
// Shared types and constants of the column z-score standardiser.
// ----------------------------------------------------------------------------
package czs_pkg;

  localparam int MaxSamples = 64;
  localparam int AddrW      = $clog2(MaxSamples);
  localparam int CountW     = $clog2(MaxSamples + 1);
  localparam int SumW       = 38;
  localparam int DvdW       = 86;
  localparam int DvsW       = 43;
  localparam int NbW        = 7;
  localparam int StdW       = 43;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               final_sample;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] zscore;
    logic               final_result;
  } result_t;

  // Write port of the sample store.
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [31:0]      data;
  } mem_wr_t;

  // One column handed from the front to the back.
  typedef struct packed {
    logic                   valid;
    logic [CountW-1:0]      count;
    logic signed [SumW-1:0] sum;
  } job_t;

  typedef struct packed {
    logic job_pop;
    logic run_done;
  } back_status_t;

  // Request to the shared divider: dividend left-aligned, nb quotient bits.
  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [NbW-1:0]  nb;
    logic [DvsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DvdW-1:0] quotient;
  } div_rsp_t;

endpackage

@@ sv/czs_front.sv @@
// ----------------------------------------------------------------------------
// czs_front
// Accepts samples, writes them to the store, keeps count and running sum and
// hands a finished column to the back through a one-entry job queue.
// ----------------------------------------------------------------------------
module czs_front
  import czs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push,
  output logic         full,
  input  sample_t      in_data_i,
  input  back_status_t status_i,
  output mem_wr_t      mem_wr_o,
  output job_t         job_o
);

  logic                   accept;
  logic                   has_room;
  logic [CountW-1:0]      count_q, count_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic                   wait_q, wait_d;
  job_t                   job_q, job_d;

  assign full     = wait_q;
  assign accept   = push && !wait_q;
  assign has_room = count_q < CountW'(MaxSamples);

  assign mem_wr_o.en   = accept && has_room;
  assign mem_wr_o.addr = count_q[AddrW-1:0];
  assign mem_wr_o.data = in_data_i.sample;
  assign job_o         = job_q;

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    wait_d  = wait_q;
    job_d   = job_q;
    if (status_i.job_pop) begin
      job_d.valid = 1'b0;
    end
    if (status_i.run_done) begin
      wait_d = 1'b0;
    end
    if (accept) begin
      if (has_room) begin
        count_d = count_q + CountW'(1);
        sum_d   = sum_q + SumW'(in_data_i.sample);
      end
      if (in_data_i.final_sample) begin
        // A column holds at least one sample; the closing sample is stored while there is room.
        job_d.valid = 1'b1;
        job_d.count = count_d;
        job_d.sum   = sum_d;
        count_d     = '0;
        sum_d       = '0;
        wait_d      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      wait_q  <= 1'b0;
      job_q   <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      wait_q  <= wait_d;
      job_q   <= job_d;
    end
  end

endmodule

@@ sv/czs_div.sv @@
// ----------------------------------------------------------------------------
// czs_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module czs_div
  import czs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [NbW-1:0]  cnt_q, cnt_d;
  logic [DvdW-1:0] dvd_q, dvd_d;
  logic [DvsW-1:0] dvs_q, dvs_d;
  logic [DvsW-1:0] rem_q, rem_d;
  logic [DvsW:0]   trial;

  assign trial = {rem_q, dvd_q[DvdW-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.nb;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      // Quotient bits enter at the bottom as the dividend leaves at the top.
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = DvsW'(trial - {1'b0, dvs_q});
        dvd_d = {dvd_q[DvdW-2:0], 1'b1};
      end else begin
        rem_d = trial[DvsW-1:0];
        dvd_d = {dvd_q[DvdW-2:0], 1'b0};
      end
      cnt_d = cnt_q - NbW'(1);
      if (cnt_q == NbW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

@@ sv/czs_back.sv @@
// ----------------------------------------------------------------------------
// czs_back
// Sequencer that computes mean, deviation and the standardised values of one
// column, and holds the sample store and the result register.
// ----------------------------------------------------------------------------
module czs_back
  import czs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  mem_wr_t      mem_wr_i,
  input  job_t         job_i,
  output back_status_t status_o,
  output div_req_t     div_req_o,
  input  div_rsp_t     div_rsp_i,
  output logic         empty,
  input  logic         pop,
  output result_t      out_data_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StMean  = 4'd1;
  localparam logic [3:0] StVRd   = 4'd2;
  localparam logic [3:0] StVSq   = 4'd3;
  localparam logic [3:0] StVAcc  = 4'd4;
  localparam logic [3:0] StVDiv  = 4'd5;
  localparam logic [3:0] StSqrt  = 4'd6;
  localparam logic [3:0] StZRd   = 4'd7;
  localparam logic [3:0] StZDiv  = 4'd8;
  localparam logic [3:0] StZWait = 4'd9;
  localparam logic [3:0] StZOut  = 4'd10;

  localparam logic [StdW-1:0] StdOne = StdW'(1) << 24;

  logic [31:0] mem_q [MaxSamples];
  logic [31:0] rdata_q;

  logic [3:0]               state_q, state_d;
  logic [CountW-1:0]        n_q, n_d;
  logic [CountW-1:0]        k_q, k_d;
  logic                     mneg_q, mneg_d;
  logic signed [33:0]       mean_q, mean_d;
  logic [63:0]              prod_q, prod_d;
  logic [69:0]              qacc_q, qacc_d;
  logic [DvdW-1:0]          rad_q, rad_d;
  logic [45:0]              srem_q, srem_d;
  logic [StdW-1:0]          root_q, root_d;
  logic [5:0]               sq_cnt_q, sq_cnt_d;
  logic [StdW-1:0]          std_q, std_d;
  logic                     zneg_q, zneg_d;
  logic                     ovalid_q, ovalid_d;
  result_t                  out_q, out_d;

  logic signed [40:0] num;
  logic [40:0]        num_mag;
  logic signed [33:0] dev;
  logic [31:0]        dev_mag;
  logic [46:0]        rem2;
  logic [46:0]        trial;
  logic [DvdW-1:0]    qv;
  logic [31:0]        zval;
  logic               last_k;

  always_ff @(posedge clk_i) begin
    if (mem_wr_i.en) begin
      mem_q[mem_wr_i.addr] <= mem_wr_i.data;
    end
    rdata_q <= mem_q[k_q[AddrW-1:0]];
  end

  // Mean rounded to nearest with ties upward: floor((2S + N) / 2N).
  assign num     = 41'(job_i.sum) * 41'sd2 + 41'(job_i.count);
  assign num_mag = num[40] ? 41'(-num) + 41'({job_i.count, 1'b0}) - 41'd1
                           : 41'(num);

  assign dev     = 34'(signed'(rdata_q)) - mean_q;
  assign dev_mag = dev[33] ? 32'(-dev) : dev[31:0];

  assign rem2  = {srem_q[44:0], rad_q[DvdW-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};

  assign qv     = div_rsp_i.quotient;
  assign last_k = (k_q + CountW'(1)) == n_q;

  always_comb begin
    if (zneg_q) begin
      zval = (|qv[DvdW-1:31]) ? 32'h8000_0000 : 32'(-qv[31:0]);
    end else begin
      zval = (|qv[DvdW-1:31]) ? 32'h7FFF_FFFF : qv[31:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    k_d       = k_q;
    mneg_d    = mneg_q;
    mean_d    = mean_q;
    prod_d    = prod_q;
    qacc_d    = qacc_q;
    rad_d     = rad_q;
    srem_d    = srem_q;
    root_d    = root_q;
    sq_cnt_d  = sq_cnt_q;
    std_d     = std_q;
    zneg_d    = zneg_q;
    ovalid_d  = ovalid_q && !pop;
    out_d     = out_q;
    status_o  = '0;
    div_req_o = '0;
    case (state_q)
      StIdle: begin
        if (job_i.valid) begin
          status_o.job_pop   = 1'b1;
          n_d                = job_i.count;
          mneg_d             = num[40];
          div_req_o.start    = 1'b1;
          div_req_o.dividend = {num_mag, {(DvdW-41){1'b0}}};
          div_req_o.nb       = NbW'(41);
          div_req_o.divisor  = DvsW'({job_i.count, 1'b0});
          state_d            = StMean;
        end
      end
      StMean: begin
        if (div_rsp_i.done) begin
          mean_d = mneg_q ? 34'(-qv[33:0]) : qv[33:0];
          k_d    = '0;
          qacc_d = '0;
          if (n_q < CountW'(2)) begin
            std_d   = StdOne;
            state_d = StZRd;
          end else begin
            state_d = StVRd;
          end
        end
      end
      StVRd: begin
        state_d = StVSq;
      end
      StVSq: begin
        prod_d  = 64'(dev_mag) * 64'(dev_mag);
        state_d = StVAcc;
      end
      StVAcc: begin
        qacc_d = qacc_q + 70'(prod_q);
        k_d    = k_q + CountW'(1);
        if (last_k) begin
          state_d = StVDiv;
        end else begin
          state_d = StVRd;
        end
      end
      StVDiv: begin
        if (!div_rsp_i.busy && !div_rsp_i.done) begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = {qacc_q, 16'h0000};
          div_req_o.nb       = NbW'(DvdW);
          div_req_o.divisor  = DvsW'(n_q - CountW'(1));
        end else if (div_rsp_i.done) begin
          rad_d    = qv;
          srem_d   = '0;
          root_d   = '0;
          sq_cnt_d = 6'(StdW);
          state_d  = StSqrt;
        end
      end
      StSqrt: begin
        // Bit-pair square root: two radicand bits in, one root bit out.
        if (rem2 >= trial) begin
          srem_d = 46'(rem2 - trial);
          root_d = {root_q[StdW-2:0], 1'b1};
        end else begin
          srem_d = rem2[45:0];
          root_d = {root_q[StdW-2:0], 1'b0};
        end
        rad_d    = {rad_q[DvdW-3:0], 2'b00};
        sq_cnt_d = sq_cnt_q - 6'd1;
        if (sq_cnt_q == 6'd1) begin
          std_d   = (root_d == '0) ? StdOne : root_d;
          k_d     = '0;
          state_d = StZRd;
        end
      end
      StZRd: begin
        state_d = StZDiv;
      end
      StZDiv: begin
        zneg_d             = dev[33];
        div_req_o.start    = 1'b1;
        div_req_o.dividend = {dev_mag, 32'h0, {(DvdW-64){1'b0}}};
        div_req_o.nb       = NbW'(64);
        div_req_o.divisor  = std_q;
        state_d            = StZWait;
      end
      StZWait: begin
        if (div_rsp_i.done) begin
          state_d = StZOut;
        end
      end
      StZOut: begin
        // The quotient stays in the divider until the next start.
        if (!ovalid_q || pop) begin
          out_d.zscore       = zval;
          out_d.final_result = last_k;
          ovalid_d           = 1'b1;
          k_d                = k_q + CountW'(1);
          if (last_k) begin
            status_o.run_done = 1'b1;
            state_d           = StIdle;
          end else begin
            state_d = StZRd;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      n_q      <= '0;
      k_q      <= '0;
      sq_cnt_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      n_q      <= n_d;
      k_q      <= k_d;
      sq_cnt_q <= sq_cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mneg_q <= mneg_d;
    mean_q <= mean_d;
    prod_q <= prod_d;
    qacc_q <= qacc_d;
    rad_q  <= rad_d;
    srem_q <= srem_d;
    root_q <= root_d;
    std_q  <= std_d;
    zneg_q <= zneg_d;
    out_q  <= out_d;
  end

  assign empty      = !ovalid_q;
  assign out_data_o = out_q;

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_o.start |-> !div_rsp_i.busy)
    else $error("divider started while busy");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !pop) |=> (ovalid_q && $stable(out_q)))
    else $error("waiting result overwritten");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> (k_q < n_q || state_q == StMean || state_q == StVDiv
                             || state_q == StSqrt))
    else $error("sample index beyond column length");

  a_idle_divider: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !div_rsp_i.busy)
    else $error("divider busy while sequencer idle");

endmodule

@@ sv/column_zscore_standardizer_core.sv @@
// ----------------------------------------------------------------------------
// column_zscore_standardizer_core
// Standardises a column of Q16.16 samples to Q8.24 z-scores.
// ----------------------------------------------------------------------------
// Loading accepts a sample per push; the input is then full until the run ends.
// A run is paced by the one-bit-per-cycle divider shared by mean, variance and
// each z-score, and by the 43-step square root. A single-sample column skips
// variance and square root.
// Reset clears all control state at once; no clearing pass is needed.
module column_zscore_standardizer_core
  import czs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push,
  output logic    full,
  input  sample_t in_data_i,
  output logic    empty,
  input  logic    pop,
  output result_t out_data_o
);

  mem_wr_t      mem_wr;
  job_t         job;
  back_status_t status;
  div_req_t     div_req;
  div_rsp_t     div_rsp;

  czs_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_data_i (in_data_i),
    .status_i  (status),
    .mem_wr_o  (mem_wr),
    .job_o     (job)
  );

  czs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  czs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mem_wr_i   (mem_wr),
    .job_i      (job),
    .status_o   (status),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

endmodule
